// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MCFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("motor command frame pack assertion failed");

// Property checked on every clock edge, reset included.
`define MCFP_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("motor command frame pack assertion failed");

`endif

// ===== rtl/mcfp_pkg.sv =====
package mcfp_pkg;

  // Control modes. Code 3 is unused and packs as position mode.
  localparam logic [1:0] OP_IMPEDANCE = 2'd0;
  localparam logic [1:0] OP_SPEED     = 2'd1;
  localparam logic [1:0] OP_POSITION  = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_MIN    = 3'd0;
  localparam logic [2:0] REG_POS_MAX    = 3'd1;
  localparam logic [2:0] REG_VEL_MIN    = 3'd2;
  localparam logic [2:0] REG_VEL_MAX    = 3'd3;
  localparam logic [2:0] REG_TORQUE_MAX = 3'd4;
  localparam logic [2:0] REG_KP_MAX     = 3'd5;
  localparam logic [2:0] REG_KD_MAX     = 3'd6;
  localparam logic [2:0] REG_KI_MAX     = 3'd7;

  localparam int NUM_LANES = 5;
  localparam int QBITS     = 31;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         motor_id;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  frame_id;
    logic [63:0] frame_bytes;
  } frame_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] wdata;
  } cfg_wr_t;

  // Full-scale code 2^bits - 1 for a code width of bits.
  function automatic logic [30:0] full_code(input logic [4:0] bits);
    return (31'(1) << bits) - 31'(1);
  endfunction

endpackage

// ===== rtl/mcfp_if.sv =====
interface mcfp_cmd_if;
  logic             valid;
  logic             ready;
  mcfp_pkg::cmd_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcfp_frame_if;
  logic             valid;
  logic             ready;
  mcfp_pkg::frame_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mcfp_cfg_if;
  logic              valid;
  logic              ready;
  mcfp_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/motor_command_frame_pack_core.sv =====
// Channel   Direction  Payload                                   Beat when
// in_ch     sink       opcode, motor_id, value_a .. value_e      valid && ready
// out_ch    source     frame_id, frame_bytes                     valid && ready
// cfg_ch    sink       index (3 bits), wdata (32 bits)           valid && ready
//
// An input beat reaches the output through one setup stage, one multiply
// stage, 31 restoring divide stages, one quotient bit each, and the output
// register. A new command is taken every cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// ranges. When the output beat stalls, the whole pipeline holds in place.
module motor_command_frame_pack_core (
  input  logic                clk,
  input  logic                rst_n,
  mcfp_cmd_if.sink            in_ch,
  mcfp_frame_if.source        out_ch,
  mcfp_cfg_if.sink            cfg_ch
);

  localparam int NL = mcfp_pkg::NUM_LANES;
  localparam int QB = mcfp_pkg::QBITS;

  // Per-lane operands after range setup.
  typedef struct packed {
    logic [31:0] d;
    logic [31:0] span;
    logic [30:0] full;
    logic        zero;
    logic        sat;
  } pre_t;

  // Per-lane state while the quotient is formed.
  typedef struct packed {
    logic [31:0] span;
    logic [32:0] rem;
    logic [30:0] nlo;
    logic [30:0] q;
    logic [30:0] full;
    logic        zero;
    logic        sat;
  } lane_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] id;
  } ctl_t;

  // Configuration registers.
  logic signed [31:0] pos_min_r, pos_max_r, vel_min_r, vel_max_r;
  logic [30:0]        torque_max_r, kp_max_r, kd_max_r, ki_max_r;

  // The whole pipeline advances when the output register is free or drained.
  logic adv;
  logic out_valid_r;
  mcfp_pkg::frame_t out_r, out_nxt;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_min_r    <= -32'sd823550;
      pos_max_r    <= 32'sd823550;
      vel_min_r    <= -32'sd2949120;
      vel_max_r    <= 32'sd2949120;
      torque_max_r <= 31'd1179648;
      kp_max_r     <= 31'd32768000;
      kd_max_r     <= 31'd327680;
      ki_max_r     <= 31'd327680;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        mcfp_pkg::REG_POS_MIN:    pos_min_r    <= cfg_ch.data.wdata;
        mcfp_pkg::REG_POS_MAX:    pos_max_r    <= cfg_ch.data.wdata;
        mcfp_pkg::REG_VEL_MIN:    vel_min_r    <= cfg_ch.data.wdata;
        mcfp_pkg::REG_VEL_MAX:    vel_max_r    <= cfg_ch.data.wdata;
        mcfp_pkg::REG_TORQUE_MAX: torque_max_r <= cfg_ch.data.wdata[30:0];
        mcfp_pkg::REG_KP_MAX:     kp_max_r     <= cfg_ch.data.wdata[30:0];
        mcfp_pkg::REG_KD_MAX:     kd_max_r     <= cfg_ch.data.wdata[30:0];
        mcfp_pkg::REG_KI_MAX:     ki_max_r     <= cfg_ch.data.wdata[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Setup stage: pick value, range and code width for each lane, clamp the
  // torque in impedance mode, sort out empty-range, below-range, saturated cases.
  // Lanes: 0 value_a, 1 value_b, 2 value_c, 3 value_d, 4 value_e.
  // ---------------------------------------------------------------------
  logic signed [33:0] x_s [NL];
  logic signed [33:0] lo_s [NL];
  logic signed [33:0] hi_s [NL];
  logic [4:0]         bits_s [NL];
  pre_t               pre_nxt [NL];

  always_comb begin
    logic signed [33:0] pmin, pmax, vmin, vmax, tmax, kpm, kdm, kim, ev;
    logic signed [33:0] dl, sp;
    pmin = 34'(pos_min_r);
    pmax = 34'(pos_max_r);
    vmin = 34'(vel_min_r);
    vmax = 34'(vel_max_r);
    tmax = $signed({3'b000, torque_max_r});
    kpm  = $signed({3'b000, kp_max_r});
    kdm  = $signed({3'b000, kd_max_r});
    kim  = $signed({3'b000, ki_max_r});
    ev   = 34'(in_ch.data.value_e);

    x_s[0] = 34'(in_ch.data.value_a);
    x_s[1] = 34'(in_ch.data.value_b);
    x_s[2] = 34'(in_ch.data.value_c);
    x_s[3] = 34'(in_ch.data.value_d);
    // Gains 2 and 3 use the same ranges in every mode.
    lo_s[2] = '0;  hi_s[2] = kpm;  bits_s[2] = 5'd12;
    lo_s[3] = '0;  hi_s[3] = kdm;  bits_s[3] = 5'd12;

    unique case (in_ch.data.opcode)
      mcfp_pkg::OP_IMPEDANCE: begin
        if (ev > tmax) ev = tmax;
        if (ev < -tmax) ev = -tmax;
        lo_s[0] = pmin;  hi_s[0] = pmax;  bits_s[0] = 5'd15;
        lo_s[1] = vmin;  hi_s[1] = vmax;  bits_s[1] = 5'd12;
        lo_s[4] = -tmax; hi_s[4] = tmax;  bits_s[4] = 5'd12;
      end
      mcfp_pkg::OP_SPEED: begin
        lo_s[0] = vmin;  hi_s[0] = vmax;  bits_s[0] = 5'd31;
        lo_s[1] = '0;    hi_s[1] = kpm;   bits_s[1] = 5'd16;
        lo_s[4] = '0;    hi_s[4] = kim;   bits_s[4] = 5'd16;
      end
      default: begin
        lo_s[0] = pmin;  hi_s[0] = pmax;  bits_s[0] = 5'd15;
        lo_s[1] = '0;    hi_s[1] = kpm;   bits_s[1] = 5'd12;
        lo_s[4] = '0;    hi_s[4] = kim;   bits_s[4] = 5'd12;
      end
    endcase
    x_s[4] = ev;

    for (int i = 0; i < NL; i++) begin
      dl = x_s[i] - lo_s[i];
      sp = hi_s[i] - lo_s[i];
      pre_nxt[i].d    = dl[31:0];
      pre_nxt[i].span = sp[31:0];
      pre_nxt[i].full = mcfp_pkg::full_code(bits_s[i]);
      pre_nxt[i].zero = (hi_s[i] <= lo_s[i]) || (x_s[i] <= lo_s[i]);
      pre_nxt[i].sat  = (dl >= sp);
    end
  end

  pre_t  pre_r [NL];
  ctl_t  c1_r;
  logic  v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r   <= pre_nxt;
      c1_r.op <= in_ch.data.opcode;
      c1_r.id <= in_ch.data.motor_id;
    end
  end

  // ---------------------------------------------------------------------
  // Multiply stage: numerator d * (2^bits - 1), then split it into the
  // starting remainder (top bits, already below span) and the bits that the
  // divide stages shift in one at a time.
  // ---------------------------------------------------------------------
  lane_t ln_r [QB+1][NL];
  ctl_t  c_r  [QB+1];
  logic  v_r  [QB+1];
  lane_t mul_nxt [NL];

  always_comb begin
    logic [62:0] prod;
    for (int i = 0; i < NL; i++) begin
      prod = 63'(pre_r[i].d) * 63'(pre_r[i].full);
      mul_nxt[i].span = pre_r[i].span;
      mul_nxt[i].rem  = {1'b0, prod[62:31]};
      mul_nxt[i].nlo  = prod[30:0];
      mul_nxt[i].q    = '0;
      mul_nxt[i].full = pre_r[i].full;
      mul_nxt[i].zero = pre_r[i].zero;
      mul_nxt[i].sat  = pre_r[i].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_r[0] <= mul_nxt;
      c_r[0]  <= c1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Restoring divide: each stage brings down one numerator bit and forms
  // one quotient bit with a 33-bit compare and subtract.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < QB; k++) begin : g_div
    lane_t div_nxt [NL];

    always_comb begin
      logic [32:0] r2;
      logic        qb;
      for (int i = 0; i < NL; i++) begin
        r2 = {ln_r[k][i].rem[31:0], ln_r[k][i].nlo[30]};
        qb = (r2 >= {1'b0, ln_r[k][i].span});
        div_nxt[i]      = ln_r[k][i];
        div_nxt[i].rem  = qb ? (r2 - {1'b0, ln_r[k][i].span}) : r2;
        div_nxt[i].nlo  = {ln_r[k][i].nlo[29:0], 1'b0};
        div_nxt[i].q    = {ln_r[k][i].q[29:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ln_r[k+1] <= div_nxt;
        c_r[k+1]  <= c_r[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: apply the special cases and pack the frame.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [30:0] code [NL];
    for (int i = 0; i < NL; i++) begin
      if (ln_r[QB][i].zero) begin
        code[i] = '0;
      end else if (ln_r[QB][i].sat) begin
        code[i] = ln_r[QB][i].full;
      end else begin
        code[i] = ln_r[QB][i].q;
      end
    end
    out_nxt.frame_id = c_r[QB].id;
    unique case (c_r[QB].op)
      mcfp_pkg::OP_SPEED: begin
        out_nxt.frame_bytes = {1'b0, code[0], code[1][15:0], code[4][15:0]};
      end
      default: begin
        // Impedance and position modes share one layout.
        out_nxt.frame_bytes = {1'b0, code[0][14:0], code[1][11:0], code[2][11:0],
                               code[3][11:0], code[4][11:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== rtl/mcfp_checker.sv =====
`include "assert_macros.svh"

module mcfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_id,
  input logic [63:0] frame_bytes
);

  // The pipeline is empty right after reset.
  `MCFP_ASSERT_ALL(a_empty_after_reset, clk, !rst_n |=> !out_valid)

  // Input is taken exactly when the output register can move.
  `MCFP_ASSERT(a_ready_follows_out, clk, rst_n, in_ready == (!out_valid || out_ready))

  // The top bit of every frame is a zero pad.
  `MCFP_ASSERT(a_pad_bit_zero, clk, rst_n, out_valid |-> !frame_bytes[63])

  // A stalled beat keeps its payload.
  `MCFP_ASSERT(a_stall_holds, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(frame_bytes) && $stable(frame_id)))

endmodule

bind motor_command_frame_pack_core mcfp_checker u_mcfp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .frame_id    (out_ch.data.frame_id),
  .frame_bytes (out_ch.data.frame_bytes)
);

// ===== tb/sv/motor_command_frame_pack_core_tb.sv =====
module motor_command_frame_pack_core_tb;

  localparam int PIPE_DEPTH = 34;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_COMMANDS = 1250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  mcfp_cmd_if   cmd_ch ();
  mcfp_frame_if frame_ch ();
  mcfp_cfg_if   cfg_ch ();

  motor_command_frame_pack_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_ch.sink),
    .out_ch(frame_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // The bench's own copy of the eight range registers, held as 64-bit signed
  // values so that min/max differences never overflow.
  logic signed [63:0] rng_pos_min, rng_pos_max, rng_vel_min, rng_vel_max;
  logic signed [63:0] rng_torque_max, rng_kp_max, rng_kd_max, rng_ki_max;

  mcfp_pkg::frame_t frames_due[$];
  int     mismatches;
  int     frames_seen;
  int     stall_cycles;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     kind_count[4];
  bit     ready_on;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Exact floor((x - lo) * (2^bits - 1) / (hi - lo)), saturating at both ends.
  // An empty or inverted range always quantizes to zero.
  function automatic logic [63:0] quantize(input logic signed [63:0] x,
                                           input logic signed [63:0] lo,
                                           input logic signed [63:0] hi,
                                           input int bits);
    logic [63:0] full_scale, span, offset;
    full_scale = (64'd1 << bits) - 64'd1;
    if (hi <= lo || x <= lo) return 64'd0;
    span = 64'(hi - lo);
    offset = 64'(x - lo);
    if (offset >= span) return full_scale;
    return (offset * full_scale) / span;
  endfunction

  function automatic mcfp_pkg::frame_t pack_command(input mcfp_pkg::cmd_t cmd);
    mcfp_pkg::frame_t f;
    logic signed [63:0] a, b, c, d, e;
    logic [63:0] word;
    a = 64'(cmd.value_a);
    b = 64'(cmd.value_b);
    c = 64'(cmd.value_c);
    d = 64'(cmd.value_d);
    e = 64'(cmd.value_e);
    if (cmd.opcode == mcfp_pkg::OP_IMPEDANCE) begin
      // Torque is clamped into its symmetric range before quantizing.
      if (e > rng_torque_max) e = rng_torque_max;
      if (e < -rng_torque_max) e = -rng_torque_max;
      word = quantize(a, rng_pos_min, rng_pos_max, 15) << 48;
      word |= quantize(b, rng_vel_min, rng_vel_max, 12) << 36;
      word |= quantize(c, 0, rng_kp_max, 12) << 24;
      word |= quantize(d, 0, rng_kd_max, 12) << 12;
      word |= quantize(e, -rng_torque_max, rng_torque_max, 12);
    end else if (cmd.opcode == mcfp_pkg::OP_SPEED) begin
      word = quantize(a, rng_vel_min, rng_vel_max, 31) << 32;
      word |= quantize(b, 0, rng_kp_max, 16) << 16;
      word |= quantize(e, 0, rng_ki_max, 16);
    end else begin
      // Position mode; the unused fourth code packs the same way.
      word = quantize(a, rng_pos_min, rng_pos_max, 15) << 48;
      word |= quantize(b, 0, rng_kp_max, 12) << 36;
      word |= quantize(c, 0, rng_kp_max, 12) << 24;
      word |= quantize(d, 0, rng_kd_max, 12) << 12;
      word |= quantize(e, 0, rng_ki_max, 12);
    end
    f.frame_id = cmd.motor_id;
    f.frame_bytes = word;
    return f;
  endfunction

  function automatic void load_default_ranges();
    rng_pos_min = -64'sd823550;
    rng_pos_max = 64'sd823550;
    rng_vel_min = -64'sd2949120;
    rng_vel_max = 64'sd2949120;
    rng_torque_max = 64'sd1179648;
    rng_kp_max = 64'sd32768000;
    rng_kd_max = 64'sd327680;
    rng_ki_max = 64'sd327680;
  endfunction

  // Drive one register write and mirror it. Range bounds are signed 32-bit,
  // the maxima are 31-bit unsigned. Valid is dropped after each write.
  task automatic write_range(input logic [2:0] idx, input logic [31:0] value);
    cfg_ch.data <= '{index: idx, wdata: value};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      mcfp_pkg::REG_POS_MIN:    rng_pos_min = 64'(signed'(value));
      mcfp_pkg::REG_POS_MAX:    rng_pos_max = 64'(signed'(value));
      mcfp_pkg::REG_VEL_MIN:    rng_vel_min = 64'(signed'(value));
      mcfp_pkg::REG_VEL_MAX:    rng_vel_max = 64'(signed'(value));
      mcfp_pkg::REG_TORQUE_MAX: rng_torque_max = 64'(value[30:0]);
      mcfp_pkg::REG_KP_MAX:     rng_kp_max = 64'(value[30:0]);
      mcfp_pkg::REG_KD_MAX:     rng_kd_max = 64'(value[30:0]);
      default:                  rng_ki_max = 64'(value[30:0]);
    endcase
  endtask

  task automatic write_all_ranges(input logic [31:0] pmin, input logic [31:0] pmax,
                                  input logic [31:0] vmin, input logic [31:0] vmax,
                                  input logic [31:0] tmax, input logic [31:0] kpm,
                                  input logic [31:0] kdm, input logic [31:0] kim);
    write_range(mcfp_pkg::REG_POS_MIN, pmin);
    write_range(mcfp_pkg::REG_POS_MAX, pmax);
    write_range(mcfp_pkg::REG_VEL_MIN, vmin);
    write_range(mcfp_pkg::REG_VEL_MAX, vmax);
    write_range(mcfp_pkg::REG_TORQUE_MAX, tmax);
    write_range(mcfp_pkg::REG_KP_MAX, kpm);
    write_range(mcfp_pkg::REG_KD_MAX, kdm);
    write_range(mcfp_pkg::REG_KI_MAX, kim);
  endtask

  // Wait for every outstanding frame, then let the pipeline drain fully so no
  // register write can race with a command still in flight.
  task automatic drain_pipeline();
    while (frames_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // Offer one command, idling first at the current sender rate. The expected
  // frame is queued at the accepting edge, before the block can answer.
  task automatic send_command(input mcfp_pkg::cmd_t cmd, input bit has_typed,
                              input mcfp_pkg::frame_t typed);
    mcfp_pkg::frame_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.data <= cmd;
    cmd_ch.valid <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    want = pack_command(cmd);
    if (has_typed && want != typed) begin
      note_mismatch("typed row vs predictor", typed.frame_bytes, want.frame_bytes);
    end
    frames_due.push_back(has_typed ? typed : want);
    kind_count[cmd.opcode]++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(6000000)) - 3000000);
      3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Most commands stay inside the configured ranges; some pick wild values so
  // both saturating ends and every input bit are reached.
  function automatic mcfp_pkg::cmd_t random_command();
    mcfp_pkg::cmd_t cmd;
    cmd.opcode = 2'($urandom_range(3));
    cmd.motor_id = 8'($urandom);
    if ($urandom_range(3) != 0) begin
      cmd.value_a = 32'(rng_pos_min + 64'($urandom_range(32'(rng_pos_max - rng_pos_min) & 32'h7FFF_FFFF)));
      if (cmd.opcode == mcfp_pkg::OP_SPEED)
        cmd.value_a = 32'(rng_vel_min + 64'($urandom_range(32'(rng_vel_max - rng_vel_min) & 32'h7FFF_FFFF)));
      cmd.value_b = 32'($urandom_range(32'(rng_kp_max)));
      if (cmd.opcode == mcfp_pkg::OP_IMPEDANCE)
        cmd.value_b = 32'(rng_vel_min + 64'($urandom_range(32'(rng_vel_max - rng_vel_min) & 32'h7FFF_FFFF)));
      cmd.value_c = 32'($urandom_range(32'(rng_kp_max)));
      cmd.value_d = 32'($urandom_range(32'(rng_kd_max)));
      cmd.value_e = 32'(signed'($urandom_range(32'(rng_torque_max) * 2 + 2)) - signed'(32'(rng_torque_max)) - 1);
    end else begin
      cmd.value_a = pick_value();
      cmd.value_b = pick_value();
      cmd.value_c = pick_value();
      cmd.value_d = pick_value();
      cmd.value_e = pick_value();
    end
    return cmd;
  endfunction

  // Directed rows. Rows with a typed frame are read straight off the default
  // ranges: the lower bound of every range packs to zero, the upper to full
  // scale. Rows without one are checked against the predictor.
  typedef struct {
    mcfp_pkg::cmd_t   cmd;
    bit               has_typed;
    mcfp_pkg::frame_t typed;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic void add_row(input logic [1:0] op, input logic [7:0] id,
                                  input logic [31:0] a, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] d,
                                  input logic [31:0] e, input bit has_typed,
                                  input logic [63:0] typed_bytes);
    directed_row_t row;
    row.cmd = '{opcode: op, motor_id: id, value_a: a, value_b: b, value_c: c,
                value_d: d, value_e: e};
    row.has_typed = has_typed;
    row.typed = '{frame_id: id, frame_bytes: typed_bytes};
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed_rows();
    // All values at or below their range floor: every code is zero.
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'h00, -32'sd823550, -32'sd2949120, 32'd0, 32'd0,
            -32'sd1179648, 1'b1, 64'h0);
    // All at the ceiling: a 15-bit code then four 12-bit codes at full scale.
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'hFF, 32'sd823550, 32'sd2949120, 32'sd32768000,
            32'sd327680, 32'sd1179648, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    // Torque far outside the clamp still saturates to full scale and zero.
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'h5A, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'hA5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b1, 64'h0);
    add_row(mcfp_pkg::OP_SPEED, 8'h01, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 64'h0);
    add_row(mcfp_pkg::OP_SPEED, 8'h80, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row(mcfp_pkg::OP_POSITION, 8'h7F, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b1, 64'h0);
    add_row(mcfp_pkg::OP_POSITION, 8'h3C, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    // The unused fourth mode packs like position mode.
    add_row(mcfp_pkg::OP_UNUSED, 8'hC3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
    // Mid-range values, checked by the predictor.
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'h12, 32'd0, 32'd0, 32'sd16384000, 32'sd163840,
            32'd0, 1'b0, 64'h0);
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'h34, 32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1,
            1'b0, 64'h0);
    add_row(mcfp_pkg::OP_SPEED, 8'h56, 32'd0, 32'sd16384000, 32'sd5, 32'sd7, 32'sd163840,
            1'b0, 64'h0);
    add_row(mcfp_pkg::OP_SPEED, 8'h78, -32'sd2949119, 32'sd1, 32'd0, 32'd0, 32'sd327679,
            1'b0, 64'h0);
    add_row(mcfp_pkg::OP_POSITION, 8'h9A, 32'sd411775, 32'sd65536, 32'sd131072,
            32'sd65536, 32'sd65536, 1'b0, 64'h0);
    add_row(mcfp_pkg::OP_UNUSED, 8'hBC, -32'sd411775, 32'sd32767999, 32'sd1, 32'sd327679,
            32'sd1, 1'b0, 64'h0);
    add_row(mcfp_pkg::OP_IMPEDANCE, 8'hDE, 32'sd823549, 32'sd2949119, 32'sd32767999,
            32'sd327679, 32'sd1179647, 1'b0, 64'h0);
  endfunction

  // Receiver: random backpressure at the current rate, and a check of every
  // frame against the oldest expectation at the accepting edge.
  always @(posedge clk) begin
    mcfp_pkg::frame_t want;
    if (!rst_n) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          note_mismatch("unexpected frame", frame_ch.data.frame_bytes, 64'h0);
        end else begin
          want = frames_due.pop_front();
          if (frame_ch.data.frame_id !== want.frame_id)
            note_mismatch("frame_id", 64'(frame_ch.data.frame_id), 64'(want.frame_id));
          if (frame_ch.data.frame_bytes !== want.frame_bytes)
            note_mismatch("frame_bytes", frame_ch.data.frame_bytes, want.frame_bytes);
        end
      end
      ready_on = ($urandom_range(99) >= recv_idle_pct);
      frame_ch.ready <= ready_on;
    end
  end

  // Watchdog: any cycle without a beat on any channel counts toward the limit.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Run one phase of random commands at the given idle rates.
  task automatic run_phase(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      send_command(random_command(), 1'b0, '0);
      // Once per phase, halfway through, hold back until the pipeline has emptied.
      if (i == count / 2) begin
        cmd_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
      end
    end
    cmd_ch.valid <= 1'b0;
  endtask

  initial begin
    int n;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    send_idle_pct = 34;
    recv_idle_pct = 58;
    load_default_ranges();
    build_directed_rows();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows run on the reset ranges.
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].has_typed,
                   directed_rows[i].typed);
    cmd_ch.valid <= 1'b0;
    drain_pipeline();

    n = RANDOM_COMMANDS / 5;
    run_phase(n, 34, 58);
    drain_pipeline();

    // Widest possible ranges: every bound at its extreme.
    write_all_ranges(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_phase(n, 58, 34);
    drain_pipeline();

    // Narrowest non-empty ranges: one unit wide, the symmetric torque range two.
    write_all_ranges(32'sd5, 32'sd6, -32'sd2, -32'sd1, 32'd1, 32'd1, 32'd1, 32'd1);
    run_phase(n / 2, 58, 34);
    drain_pipeline();

    // Inverted velocity and empty position ranges force those codes to zero.
    write_all_ranges(32'sd1000, -32'sd1000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'd1, 32'd1, 32'd1, 32'd1);
    write_range(mcfp_pkg::REG_POS_MAX, 32'sd1000);
    write_range(mcfp_pkg::REG_POS_MIN, 32'sd1000);
    run_phase(n / 2, 0, 0);
    drain_pipeline();

    // Random settings; every 31-bit maximum but the kd one can reach its top bit.
    for (int k = 0; k < 3; k++) begin
      write_all_ranges(32'(-$urandom_range(32'h3FFF_FFFF)), $urandom_range(32'h7FFF_FFFF),
                       32'(-$urandom_range(32'h3FFF_FFFF)), $urandom_range(32'h7FFF_FFFF),
                       $urandom | 32'h4000_0000 >> $urandom_range(30),
                       $urandom_range(32'h7FFF_FFFF, 1), $urandom_range(32'hFFFFF, 1),
                       $urandom_range(32'h7FFF_FFFF, 1));
      run_phase(n / 3, 0, 0);
      drain_pipeline();
    end

    load_default_ranges();
    write_all_ranges(-32'sd823550, 32'sd823550, -32'sd2949120, 32'sd2949120,
                     32'd1179648, 32'd32768000, 32'd327680, 32'd327680);
    run_phase(n, 0, 0);
    drain_pipeline();

    $display("covered %0d frames: %0d impedance, %0d speed, %0d position, %0d unused mode",
             frames_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("ranges: reset, widest, one step, inverted and random; %0d mismatches",
             mismatches);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
